### rtl/mass_spring_force_evaluator_macros.svh
// ----------------------------------------------------------------------------
// mass spring force evaluator assertion macros
// shared property forms for the checker, sampled on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef MASS_SPRING_FORCE_EVALUATOR_MACROS_SVH
`define MASS_SPRING_FORCE_EVALUATOR_MACROS_SVH

// same-cycle implication
`define MSFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/msfe_pkg.sv
// ----------------------------------------------------------------------------
// msfe_pkg
// widths, codes and reset values of the mass spring force evaluator
// ----------------------------------------------------------------------------
package msfe_pkg;

    // particle table
    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W         = 10;
    localparam int MEM_DEPTH     = (MAX_PARTICLES < (2 ** IDX_W)) ? MAX_PARTICLES
                                                                    : (2 ** IDX_W);

    // stream and config widths
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = 280;
    localparam int M_TDATA_W = 208;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // command codes carried on tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SPRING = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG    = 1'b1;

    // register reset values, q16.16
    localparam logic [31:0] GRAVITY_RST = 32'hFFFE_0000;
    localparam logic [30:0] DRAG_RST    = 31'd85197;

endpackage

### rtl/mass_spring_force_evaluator.sv
// ----------------------------------------------------------------------------
// mass_spring_force_evaluator
// q16.16 mass spring derivative engine: particle load, spring accumulate and
// derivative read over one particle table, with bit-serial arithmetic
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tdata command fields, tuser cmd
// m_axis    out        m_axis_tvalid/tready       tdata particle derivative
// cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// the arithmetic is a shift-add multiplier, a two-bit square root and a
// restoring divider that is run once per axis
// reset is synchronous and clears control and the config registers to their
// reset values; the tables are not cleared
// a read waits in its last state while an older result is not yet taken
// ----------------------------------------------------------------------------
module mass_spring_force_evaluator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // index_a, index_b, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, is_fixed,
    // rest_length, stiffness, zero fill
    input  logic [msfe_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [msfe_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // particle_index, dpos_x, dpos_y, dpos_z, force_x, force_y, force_z,
    // zero fill
    output logic [msfe_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [msfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msfe_pkg::CFG_W-1:0]      i_cfg_data
);
    import msfe_pkg::*;

    typedef enum logic [22:0] {
        ST_IDLE     = 23'h000001,
        ST_LD_MUL   = 23'h000002,
        ST_LD_SEED  = 23'h000004,
        ST_LD_WR    = 23'h000008,
        ST_RD_WAIT  = 23'h000010,
        ST_RD_OUT   = 23'h000020,
        ST_SP_RDA   = 23'h000040,
        ST_SP_RDB   = 23'h000080,
        ST_SP_DIF   = 23'h000100,
        ST_SP_SQ    = 23'h000200,
        ST_SP_ACC   = 23'h000400,
        ST_SP_SQRT  = 23'h000800,
        ST_SP_LEN   = 23'h001000,
        ST_SP_TMUL  = 23'h002000,
        ST_SP_TENS  = 23'h004000,
        ST_SP_SMUL  = 23'h008000,
        ST_SP_NUM   = 23'h010000,
        ST_SP_DIV   = 23'h020000,
        ST_SP_SHARE = 23'h040000,
        ST_SP_FRA   = 23'h080000,
        ST_SP_FWA   = 23'h100000,
        ST_SP_FRB   = 23'h200000,
        ST_SP_FWB   = 23'h400000
    } t_state;

    // magnitude of a sign-extended value
    function automatic logic [35:0] mag36(input logic [35:0] v);
        mag36 = v[35] ? (~v + 36'd1) : v;
    endfunction

    // clamp to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic [49:0] v);
        if (!v[49] && (v[48:31] != '0)) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v[49] && (v[48:31] != '1)) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // config registers
    logic [31:0] r_gravity;
    logic [30:0] r_drag;

    // control and datapath
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_addr, r_ia, r_ib;
    logic [30:0]        r_rest, r_k;
    logic [1:0]         r_ax;
    logic [5:0]         r_cnt;
    logic [95:0]        r_vel, r_pa;
    logic [35:0]        r_mul_a;
    logic [71:0]        r_mul_p;
    logic [32:0]        r_res [3];
    logic [32:0]        r_d [3];
    logic [67:0]        r_ssq, r_rad;
    logic [36:0]        r_rem;
    logic [33:0]        r_root;
    logic [31:0]        r_tens, r_q, r_nlo;
    logic               r_tneg;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // tables
    logic [95:0] r_pos_mem [MEM_DEPTH];
    logic [95:0] r_vel_mem [MEM_DEPTH];
    logic [95:0] r_frc_mem [MEM_DEPTH];
    logic        r_fix_mem [MEM_DEPTH];
    logic [95:0] r_pos_q, r_vel_q, r_frc_q;
    logic        r_fix_q;

    // input field split
    t_cmd             w_cmd;
    logic [IDX_W-1:0] w_ia, w_ib;
    logic [95:0]      w_pos, w_vel;
    logic             w_fix;
    logic [30:0]      w_rest, w_k;
    logic             w_acc, w_ia_ok, w_ib_ok, w_ld_we;

    assign w_cmd   = t_cmd'(s_axis_tuser);
    assign w_ia    = s_axis_tdata[9:0];
    assign w_ib    = s_axis_tdata[19:10];
    assign w_pos   = s_axis_tdata[115:20];
    assign w_vel   = s_axis_tdata[211:116];
    assign w_fix   = s_axis_tdata[212];
    assign w_rest  = s_axis_tdata[243:213];
    assign w_k     = s_axis_tdata[274:244];
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_ia_ok = (32'(w_ia) < MAX_PARTICLES);
    assign w_ib_ok = (32'(w_ib) < MAX_PARTICLES);
    assign w_ld_we = w_acc && (w_cmd == CMD_LOAD) && w_ia_ok;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // shift-add multiplier step, one multiplier bit per cycle
    logic [36:0] w_mul_sum;
    logic [71:0] w_mul_next;
    assign w_mul_sum  = {1'b0, r_mul_p[71:36]} + (r_mul_p[0] ? {1'b0, r_mul_a} : 37'd0);
    assign w_mul_next = {w_mul_sum, r_mul_p[35:1]};

    // round to nearest at 16 fraction bits
    logic [71:0] w_rnd;
    logic [55:0] w_rnd_m;
    assign w_rnd   = r_mul_p + 72'd32768;
    assign w_rnd_m = w_rnd[71:16];

    // square root step, two radicand bits per cycle
    logic [36:0] w_sq_rem2, w_sq_trial;
    logic        w_sq_ge;
    assign w_sq_rem2  = {r_rem[34:0], r_rad[67:66]};
    assign w_sq_trial = {1'b0, r_root, 2'b01};
    assign w_sq_ge    = (w_sq_rem2 >= w_sq_trial);

    // restoring divide step
    logic [36:0] w_dv_rem2;
    logic        w_dv_ge;
    assign w_dv_rem2 = {r_rem[35:0], r_nlo[31]};
    assign w_dv_ge   = (w_dv_rem2 >= {3'b000, r_root});

    // next axis and its operands
    logic [1:0]  w_ax_nx;
    logic [31:0] w_vel_nx;
    logic [32:0] w_dif [3];
    logic [67:0] w_ssq_sum;
    logic [35:0] w_e;
    logic [31:0] w_tens;
    logic [63:0] w_num;
    logic [31:0] w_base;
    logic [49:0] w_seed;
    assign w_ax_nx   = r_ax + 2'd1;
    assign w_vel_nx  = r_vel[32*w_ax_nx +: 32];
    assign w_ssq_sum = r_ssq + {2'b00, r_mul_p[65:0]};
    assign w_e       = {2'b00, r_root} - {5'b00000, r_rest};
    assign w_num     = r_mul_p[63:0] + {31'd0, r_root[33:1]};
    assign w_base    = (r_ax == 2'd1) ? r_gravity : 32'd0;
    assign w_seed    = r_vel[32*r_ax + 31]
                     ? ({{18{w_base[31]}}, w_base} + {2'b00, w_rnd_m[47:0]})
                     : ({{18{w_base[31]}}, w_base} - {2'b00, w_rnd_m[47:0]});

    for (genvar g = 0; g < 3; g++) begin : g_dif
        assign w_dif[g] = {r_pa[32*g + 31], r_pa[32*g +: 32]}
                        - {r_pos_q[32*g + 31], r_pos_q[32*g +: 32]};
    end

    // tension clamp: 2^31 when compressing, 2^31-1 when stretching
    always_comb begin
        if (w_rnd_m[55:31] != '0) begin
            w_tens = (w_e[35]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_tens = w_rnd_m[31:0];
        end
    end

    // force table write port
    logic        w_frc_we;
    logic [95:0] w_frc_wd;
    assign w_frc_we = (r_state == ST_LD_WR) || (r_state == ST_SP_FWA)
                   || (r_state == ST_SP_FWB);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_state == ST_LD_WR) begin
                w_frc_wd[32*i +: 32] = r_res[i][31:0];
            end else if (r_state == ST_SP_FWA) begin
                w_frc_wd[32*i +: 32] = sat32({{18{r_frc_q[32*i + 31]}}, r_frc_q[32*i +: 32]}
                                           + {{17{r_res[i][32]}}, r_res[i]});
            end else begin
                w_frc_wd[32*i +: 32] = sat32({{18{r_frc_q[32*i + 31]}}, r_frc_q[32*i +: 32]}
                                           - {{17{r_res[i][32]}}, r_res[i]});
            end
        end
    end

    // particle tables
    always_ff @(posedge i_clk) begin
        if (w_ld_we) begin
            r_pos_mem[w_ia] <= w_pos;
            r_vel_mem[w_ia] <= w_vel;
            r_fix_mem[w_ia] <= w_fix;
        end
        if (w_frc_we) begin
            r_frc_mem[r_addr] <= w_frc_wd;
        end
        r_pos_q <= r_pos_mem[r_addr];
        r_vel_q <= r_vel_mem[r_addr];
        r_frc_q <= r_frc_mem[r_addr];
        r_fix_q <= r_fix_mem[r_addr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RST;
            r_drag    <= DRAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRAVITY: r_gravity <= i_cfg_data;
                REG_DRAG:    r_drag    <= i_cfg_data[30:0];
                default:     r_drag    <= r_drag;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if ((w_cmd == CMD_LOAD) && w_ia_ok) begin
                        n_state = ST_LD_MUL;
                    end else if ((w_cmd == CMD_SPRING) && w_ia_ok && w_ib_ok) begin
                        n_state = ST_SP_RDA;
                    end else if ((w_cmd == CMD_READ) && w_ia_ok) begin
                        n_state = ST_RD_WAIT;
                    end
                end
            end
            ST_LD_MUL:   if (r_cnt == 6'd0) n_state = ST_LD_SEED;
            ST_LD_SEED:  n_state = (r_ax == 2'd2) ? ST_LD_WR : ST_LD_MUL;
            ST_LD_WR:    n_state = ST_IDLE;
            ST_RD_WAIT:  n_state = ST_RD_OUT;
            ST_RD_OUT:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            ST_SP_RDA:   n_state = ST_SP_RDB;
            ST_SP_RDB:   n_state = ST_SP_DIF;
            ST_SP_DIF:   n_state = ST_SP_SQ;
            ST_SP_SQ:    if (r_cnt == 6'd0) n_state = ST_SP_ACC;
            ST_SP_ACC:   n_state = (r_ax == 2'd2) ? ST_SP_SQRT : ST_SP_SQ;
            ST_SP_SQRT:  if (r_cnt == 6'd0) n_state = ST_SP_LEN;
            ST_SP_LEN:   n_state = (r_root == '0) ? ST_IDLE : ST_SP_TMUL;
            ST_SP_TMUL:  if (r_cnt == 6'd0) n_state = ST_SP_TENS;
            ST_SP_TENS:  n_state = ST_SP_SMUL;
            ST_SP_SMUL:  if (r_cnt == 6'd0) n_state = ST_SP_NUM;
            ST_SP_NUM:   n_state = ST_SP_DIV;
            ST_SP_DIV:   if (r_cnt == 6'd0) n_state = ST_SP_SHARE;
            ST_SP_SHARE: n_state = (r_ax == 2'd2) ? ST_SP_FRA : ST_SP_SMUL;
            ST_SP_FRA:   n_state = ST_SP_FWA;
            ST_SP_FWA:   n_state = ST_SP_FRB;
            ST_SP_FRB:   n_state = ST_SP_FWB;
            ST_SP_FWB:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result register, freed by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_RD_OUT) && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RD_OUT) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {6'd0, (r_fix_q ? 96'd0 : r_frc_q), r_vel_q, r_addr};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_addr  <= w_ia;
                r_ia    <= w_ia;
                r_ib    <= w_ib;
                r_rest  <= w_rest;
                r_k     <= w_k;
                r_vel   <= w_vel;
                r_ax    <= 2'd0;
                r_cnt   <= 6'd35;
                r_mul_a <= {5'd0, r_drag};
                r_mul_p <= {36'd0, mag36({{4{w_vel[31]}}, w_vel[31:0]})};
            end
            ST_LD_MUL, ST_SP_SQ, ST_SP_TMUL, ST_SP_SMUL: begin
                r_mul_p <= w_mul_next;
                r_cnt   <= r_cnt - 6'd1;
            end
            ST_LD_SEED: begin
                r_res[r_ax] <= {1'b0, sat32(w_seed)};
                r_ax        <= w_ax_nx;
                r_cnt       <= 6'd35;
                r_mul_p     <= {36'd0, mag36({{4{w_vel_nx[31]}}, w_vel_nx})};
            end
            ST_SP_RDA: begin
                r_addr <= r_ib;
            end
            ST_SP_RDB: begin
                r_pa <= r_pos_q;
            end
            ST_SP_DIF: begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= w_dif[i];
                end
                r_ssq   <= '0;
                r_ax    <= 2'd0;
                r_cnt   <= 6'd35;
                r_mul_a <= mag36({{3{w_dif[0][32]}}, w_dif[0]});
                r_mul_p <= {36'd0, mag36({{3{w_dif[0][32]}}, w_dif[0]})};
            end
            ST_SP_ACC: begin
                r_ssq   <= w_ssq_sum;
                r_rad   <= w_ssq_sum;
                r_rem   <= '0;
                r_root  <= '0;
                r_ax    <= w_ax_nx;
                r_cnt   <= (r_ax == 2'd2) ? 6'd33 : 6'd35;
                r_mul_a <= mag36({{3{r_d[w_ax_nx][32]}}, r_d[w_ax_nx]});
                r_mul_p <= {36'd0, mag36({{3{r_d[w_ax_nx][32]}}, r_d[w_ax_nx]})};
            end
            ST_SP_SQRT: begin
                r_rad  <= {r_rad[65:0], 2'b00};
                r_rem  <= w_sq_ge ? (w_sq_rem2 - w_sq_trial) : w_sq_rem2;
                r_root <= {r_root[32:0], w_sq_ge};
                r_cnt  <= r_cnt - 6'd1;
            end
            ST_SP_LEN: begin
                r_tneg  <= w_e[35];
                r_cnt   <= 6'd35;
                r_mul_a <= {5'd0, r_k};
                r_mul_p <= {36'd0, mag36(w_e)};
            end
            ST_SP_TENS: begin
                r_tens  <= w_tens;
                r_ax    <= 2'd0;
                r_cnt   <= 6'd35;
                r_mul_a <= {4'd0, w_tens};
                r_mul_p <= {36'd0, mag36({{3{r_d[0][32]}}, r_d[0]})};
            end
            ST_SP_NUM: begin
                r_rem <= {5'd0, w_num[63:32]};
                r_nlo <= w_num[31:0];
                r_q   <= '0;
                r_cnt <= 6'd31;
            end
            ST_SP_DIV: begin
                r_rem <= w_dv_ge ? (w_dv_rem2 - {3'b000, r_root}) : w_dv_rem2;
                r_nlo <= {r_nlo[30:0], 1'b0};
                r_q   <= {r_q[30:0], w_dv_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_SP_SHARE: begin
                // force on the first endpoint is minus tension along d over length
                r_res[r_ax] <= ((!r_tneg) != r_d[r_ax][32]) ? (~{1'b0, r_q} + 33'd1)
                                                            : {1'b0, r_q};
                r_ax    <= w_ax_nx;
                r_cnt   <= 6'd35;
                r_addr  <= r_ia;
                r_mul_a <= {4'd0, r_tens};
                r_mul_p <= {36'd0, mag36({{3{r_d[w_ax_nx][32]}}, r_d[w_ax_nx]})};
            end
            ST_SP_FWA: begin
                r_addr <= r_ib;
            end
            default: begin
                r_ax <= r_ax;
            end
        endcase
    end

endmodule

### rtl/msfe_chk.sv
// ----------------------------------------------------------------------------
// msfe_chk
// port-level checks of the mass spring force evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "mass_spring_force_evaluator_macros.svh"

module msfe_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [msfe_pkg::CMD_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);
    import msfe_pkg::*;

    logic w_in_xfer;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // a pending result stays until its transfer
    `MSFE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

    // a load, spring or read keeps the input closed in the next cycle
    `MSFE_ASSERT_NXT(a_busy_after_cmd, w_in_xfer && (s_axis_tuser != CMD_NONE), !s_axis_tready, "input open while busy")

    // a new result only comes out of a command in progress
    `MSFE_ASSERT_IMP(a_result_from_cmd, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without command")

    // a load never yields a result on its own
    `MSFE_ASSERT_NXT(a_no_result_load, w_in_xfer && (s_axis_tuser == CMD_LOAD) && !m_axis_tvalid, !m_axis_tvalid, "load produced a result")

endmodule

bind mass_spring_force_evaluator msfe_chk u_msfe_chk (.*);

### tb/sv/msfe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msfe_checker
// watches the input, output and register channels of the mass spring force
// evaluator, keeps its own copy of the particle table, predicts every read
// and compares each output transfer field by field against the oldest one
// ----------------------------------------------------------------------------
module msfe_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_valid,
    input  logic                            i_s_ready,
    input  logic [msfe_pkg::S_TDATA_W-1:0]  i_s_data,
    input  logic [msfe_pkg::CMD_W-1:0]      i_s_user,
    input  logic                            i_m_valid,
    input  logic                            i_m_ready,
    input  logic [msfe_pkg::M_TDATA_W-1:0]  i_m_data,
    input  logic                            i_cfg_we,
    input  logic [msfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msfe_pkg::CFG_W-1:0]      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import msfe_pkg::*;

    // packed from the top down, so idx lands in the lowest bits
    typedef struct packed {
        logic signed [31:0] fz, fy, fx;
        logic signed [31:0] dpz, dpy, dpx;
        logic [9:0]         idx;
    } t_deriv;

    logic signed [31:0] pos_x [MAX_PARTICLES];
    logic signed [31:0] pos_y [MAX_PARTICLES];
    logic signed [31:0] pos_z [MAX_PARTICLES];
    logic signed [31:0] vel_x [MAX_PARTICLES];
    logic signed [31:0] vel_y [MAX_PARTICLES];
    logic signed [31:0] vel_z [MAX_PARTICLES];
    logic signed [31:0] frc_x [MAX_PARTICLES];
    logic signed [31:0] frc_y [MAX_PARTICLES];
    logic signed [31:0] frc_z [MAX_PARTICLES];
    logic               anchored [MAX_PARTICLES];
    logic signed [31:0] gravity;
    logic [30:0]        drag;
    t_deriv             deriv_queue [$];

    assign o_pending = deriv_queue.size();

    function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -128'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] mag(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // q16.16 product magnitude, rounded half away from zero
    function automatic logic signed [127:0] qmul(input logic signed [127:0] a,
                                                 input logic signed [127:0] b);
        return (a * b + 128'sd32768) >>> 16;
    endfunction

    // gravity/drag seed of one force component
    function automatic logic signed [31:0] seed_force(input logic signed [127:0] base,
                                                      input logic signed [31:0] v);
        logic signed [127:0] m;
        m = qmul({97'd0, drag}, mag(v));
        return sat32(base - ((v < 0) ? -m : m));
    endfunction

    function automatic logic signed [127:0] share(input logic signed [127:0] tens,
                                                  input logic tneg,
                                                  input logic signed [127:0] d,
                                                  input logic signed [127:0] len);
        logic signed [127:0] q;
        q = (tens * mag(d) + len / 2) / len;
        return ((!tneg) != (d < 0)) ? -q : q;
    endfunction

    task automatic apply_spring(input int a, input int b,
                                input logic [30:0] rest, input logic [30:0] k);
        logic signed [127:0] dx, dy, dz, sq, t, len, e, tens, cx, cy, cz;
        logic                tneg;
        dx = 128'(pos_x[a]) - 128'(pos_x[b]);
        dy = 128'(pos_y[a]) - 128'(pos_y[b]);
        dz = 128'(pos_z[a]) - 128'(pos_z[b]);
        sq = dx * dx + dy * dy + dz * dz;
        len = 0;
        for (int bit_i = 33; bit_i >= 0; bit_i--) begin
            t = len | (128'sd1 <<< bit_i);
            if (t * t <= sq) len = t;
        end
        // coincident endpoints add nothing
        if (len == 0) return;
        e = len - 128'({97'd0, rest});
        tneg = (e < 0);
        tens = qmul({97'd0, k}, mag(e));
        if (tens > 128'sd2147483648) tens = 128'sd2147483648;
        if (!tneg && tens > 128'sd2147483647) tens = 128'sd2147483647;
        cx = share(tens, tneg, dx, len);
        cy = share(tens, tneg, dy, len);
        cz = share(tens, tneg, dz, len);
        frc_x[a] = sat32(128'(frc_x[a]) + cx);
        frc_y[a] = sat32(128'(frc_y[a]) + cy);
        frc_z[a] = sat32(128'(frc_z[a]) + cz);
        frc_x[b] = sat32(128'(frc_x[b]) - cx);
        frc_y[b] = sat32(128'(frc_y[b]) - cy);
        frc_z[b] = sat32(128'(frc_z[b]) - cz);
    endtask

    task automatic compare(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s expected %h actual %h", $realtime, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // register writes, accepted command transfers and result transfers
    always @(posedge i_clk) begin
        t_deriv     exp_d;
        t_deriv     act_d;
        int         ia, ib;
        if (!i_rst_n) begin
            gravity = GRAVITY_RST;
            drag    = DRAG_RST;
            deriv_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GRAVITY) gravity = i_cfg_data;
                else if (i_cfg_idx == REG_DRAG) drag = i_cfg_data[30:0];
            end
            if (i_s_valid && i_s_ready) begin
                ia = int'(i_s_data[9:0]);
                ib = int'(i_s_data[19:10]);
                case (t_cmd'(i_s_user))
                    CMD_LOAD: begin
                        pos_x[ia] = i_s_data[51:20];
                        pos_y[ia] = i_s_data[83:52];
                        pos_z[ia] = i_s_data[115:84];
                        vel_x[ia] = i_s_data[147:116];
                        vel_y[ia] = i_s_data[179:148];
                        vel_z[ia] = i_s_data[211:180];
                        anchored[ia] = i_s_data[212];
                        frc_x[ia] = seed_force(0, vel_x[ia]);
                        frc_y[ia] = seed_force(128'(gravity), vel_y[ia]);
                        frc_z[ia] = seed_force(0, vel_z[ia]);
                    end
                    CMD_SPRING: apply_spring(ia, ib, i_s_data[243:213], i_s_data[274:244]);
                    CMD_READ: begin
                        exp_d.idx = 10'(ia);
                        exp_d.dpx = vel_x[ia];
                        exp_d.dpy = vel_y[ia];
                        exp_d.dpz = vel_z[ia];
                        exp_d.fx  = anchored[ia] ? 32'sd0 : frc_x[ia];
                        exp_d.fy  = anchored[ia] ? 32'sd0 : frc_y[ia];
                        exp_d.fz  = anchored[ia] ? 32'sd0 : frc_z[ia];
                        deriv_queue = {deriv_queue, exp_d};
                    end
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                act_d = i_m_data[201:0];
                if (deriv_queue.size() == 0) begin
                    $display("%0t unexpected result transfer, actual %h", $realtime, act_d);
                    o_fail_count++;
                end else begin
                    exp_d = deriv_queue.pop_front();
                    compare("particle_index", 32'(exp_d.idx), 32'(act_d.idx));
                    compare("dpos_x", exp_d.dpx, act_d.dpx);
                    compare("dpos_y", exp_d.dpy, act_d.dpy);
                    compare("dpos_z", exp_d.dpz, act_d.dpz);
                    compare("force_x", exp_d.fx, act_d.fx);
                    compare("force_y", exp_d.fy, act_d.fy);
                    compare("force_z", exp_d.fz, act_d.fz);
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives loads, springs and reads into the mass spring force evaluator in
// random bursts over several register settings, with a stalling receiver;
// the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module testbench;
    import msfe_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_START   = 30000;
    localparam int HOLD_LEN     = 3000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata;
    logic [CMD_W-1:0]         s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [M_TDATA_W-1:0]     m_axis_tdata;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_data;
    int                       fail_count;
    int                       pending;
    int                       cycle_count;
    int                       burst_left;
    int                       loaded_list [$];
    logic                     loaded [MAX_PARTICLES];

    mass_spring_force_evaluator uut (.*);

    msfe_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // cycle count and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: one long hold-off, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
            m_axis_tready <= 1'b0;
        else case ((cycle_count / 700) % 3)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // q16.16 value: full range, small, or an extreme
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2, 3: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_u31();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1, 2: return 31'($urandom_range(0, 6 << 16));
            default: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
        endcase
    endfunction

    // one command transfer, with bursts and gaps on the sender side
    task automatic send(input t_cmd cmd, input logic [9:0] ia, input logic [9:0] ib,
                        input logic [31:0] px, py, pz, vx, vy, vz,
                        input logic fixed, input logic [30:0] rest, stiff);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, stiff, rest, fixed, vz, vy, vx, pz, py, px, ib, ia};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == CMD_LOAD && !loaded[ia]) begin
            loaded[ia] = 1'b1;
            loaded_list = {loaded_list, int'(ia)};
        end
    endtask

    task automatic load_rand(input logic [9:0] ia);
        send(CMD_LOAD, ia, $urandom, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
             rand_q(), $urandom_range(0, 3) == 0, $urandom, $urandom);
    endtask

    task automatic spring(input logic [9:0] ia, ib, input logic [30:0] rest, stiff);
        send(CMD_SPRING, ia, ib, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, rest, stiff);
    endtask

    task automatic read(input logic [9:0] ia);
        send(CMD_READ, ia, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [9:0] pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // let every result arrive and the block finish any load or spring
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] grav, input logic [30:0] drg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_GRAVITY;
        i_cfg_data <= grav;
        @(posedge i_clk);
        i_cfg_idx  <= REG_DRAG;
        i_cfg_data <= {1'b0, drg};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (loaded_list.size() < 2 || sel < 30)
                load_rand($urandom_range(0, 3) == 0 ? 10'($urandom) :
                          10'($urandom_range(0, 15)));
            else if (sel < 70)
                spring(pick_loaded(), $urandom_range(0, 9) == 0 ? pick_loaded() :
                       pick_loaded(), rand_u31(), rand_u31());
            else if (sel < 95)
                read(pick_loaded());
            else
                send(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        cycle_count   = 0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_NONE;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_GRAVITY;
        i_cfg_data    = '0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, coincident endpoints, reload, unused command
        send(CMD_LOAD, 10'd0, 10'h3FF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send(CMD_LOAD, 10'h3FF, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 31'd0, 31'd0);
        send(CMD_LOAD, 10'd1, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'd0, 32'd0, 32'd0, 1'b0, 31'd0, 31'd0);
        read(10'd0);
        read(10'h3FF);
        read(10'd1);
        spring(10'd0, 10'h3FF, 31'd0, 31'h7FFF_FFFF);
        spring(10'd0, 10'h3FF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        spring(10'd0, 10'd0, 31'd0, 31'h7FFF_FFFF);
        spring(10'd0, 10'd1, 31'd0, 31'h7FFF_FFFF);
        read(10'd0);
        read(10'd1);
        read(10'h3FF);
        send(CMD_NONE, 10'd0, 10'd1, '1, '1, '1, '1, '1, '1, 1'b1, '1, '1);
        send(CMD_LOAD, 10'd2, 10'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd0,
             32'h0000_8000, 32'hFFFF_8000, 32'd1, 1'b0, 31'd0, 31'd0);
        spring(10'd2, 10'd1, 31'h7FFF_FFFF, 31'd1);
        spring(10'd2, 10'd0, 31'h0001_0000, 31'h0002_0000);
        read(10'd2);
        send(CMD_LOAD, 10'd0, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
             1'b0, 31'd0, 31'd0);
        read(10'd0);
        read(10'd1);

        random_phase(300);
        drain();
        write_regs(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_phase(280);
        drain();
        write_regs(32'h8000_0000, 31'd0);
        random_phase(280);
        drain();
        write_regs($urandom, 31'($urandom_range(0, 4 << 16)));
        random_phase(270);
        drain();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/msfe_pkg.sv
rtl/mass_spring_force_evaluator.sv
rtl/msfe_chk.sv
tb/sv/msfe_checker.sv
tb/sv/testbench.sv
